>>> src/hbbtm_pkg.sv
`default_nettype none
package hbbtm_pkg;

   localparam int NUM_ENTRIES_DEF = 32;
   localparam int NUM_BUCKETS_DEF = 13;

   // sized for the top of the parameter ranges
   localparam int IDX_W = 8;
   localparam int BKT_W = 6;

   localparam logic [11:0] HASH_MULT = 12'd2591;
   localparam logic [7:0]  CNT_MAX   = 8'd255;

   typedef enum logic [1:0] {
      ACT_GET     = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_PIN     = 2'd2,
      ACT_UNPIN   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_HIT   = 2'd0,
      ST_MISS  = 2'd1,
      ST_NOBUF = 2'd2,
      ST_SAT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]       dev;
      logic [31:0]      blk;
      logic [BKT_W-1:0] bkt;
      logic [IDX_W-1:0] idx;
   } query_type;

   typedef struct packed {
      logic             hit_found;
      logic [IDX_W-1:0] hit_idx;
      logic [31:0]      hit_place;
      logic             hit_valid;
      logic [7:0]       hit_cnt;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic [BKT_W-1:0] free_dist;
      logic [31:0]      free_stamp;
      logic [31:0]      free_place;
      logic             tgt_valid;
      logic [7:0]       tgt_cnt;
   } scan_token_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             set_tag;
      logic [7:0]       dev;
      logic [31:0]      blk;
      logic             set_cnt;
      logic [7:0]       cnt;
      logic             set_stamp;
      logic [31:0]      stamp;
      logic             set_valid;
      logic             set_bucket;
      logic [BKT_W-1:0] bkt;
      logic [31:0]      place;
   } update_type;

endpackage
`default_nettype wire

>>> src/hbbtm_hash.sv
`default_nettype none
module hbbtm_hash #(
   parameter int NUM_BUCKETS = hbbtm_pkg::NUM_BUCKETS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [7:0]                   dev,
   input  wire logic [31:0]                  blk,
   output logic                              done,
   output logic [hbbtm_pkg::BKT_W-1:0]       bucket
);
   localparam int RW = hbbtm_pkg::BKT_W;

   // residue of (r * 256) for every possible remainder r
   function automatic logic [64*8-1:0] build_shift_tbl();
      logic [64*8-1:0] t;
      t = '0;
      for (int r = 0; r < 64; r++) begin
         t[r*8 +: 8] = 8'((r * 256) % NUM_BUCKETS);
      end
      return t;
   endfunction

   // residue of every byte value
   function automatic logic [256*8-1:0] build_byte_tbl();
      logic [256*8-1:0] t;
      t = '0;
      for (int v = 0; v < 256; v++) begin
         t[v*8 +: 8] = 8'(v % NUM_BUCKETS);
      end
      return t;
   endfunction

   localparam logic [64*8-1:0]  SHIFT_TBL = build_shift_tbl();
   localparam logic [256*8-1:0] BYTE_TBL  = build_byte_tbl();

   logic [31:0]   sum_ff;
   logic [RW-1:0] rem_ff, rem_in;
   logic [1:0]    cnt_ff;
   logic          busy_ff, done_ff;
   logic [7:0]    shift_part, byte_part;
   logic [RW:0]   fold;
   logic [19:0]   prod;

   assign prod = 20'(dev) * 20'(hbbtm_pkg::HASH_MULT);

   // one byte per step, most significant first
   always_comb begin
      shift_part = SHIFT_TBL[{rem_ff, 3'b000} +: 8];
      byte_part  = BYTE_TBL[{sum_ff[31:24], 3'b000} +: 8];
      fold       = (RW+1)'(shift_part) + (RW+1)'(byte_part);
      if (fold >= (RW+1)'(NUM_BUCKETS)) begin
         fold = fold - (RW+1)'(NUM_BUCKETS);
      end
      rem_in = RW'(fold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            sum_ff  <= 32'(prod) + blk;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            sum_ff <= {sum_ff[23:0], 8'd0};
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign bucket = rem_ff;
endmodule
`default_nettype wire

>>> src/hbbtm_cell.sv
`default_nettype none
module hbbtm_cell #(
   parameter int NUM_BUCKETS = hbbtm_pkg::NUM_BUCKETS_DEF,
   parameter int CELL_ID     = 0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hbbtm_pkg::query_type      query,
   input  wire hbbtm_pkg::update_type     upd,
   input  wire hbbtm_pkg::scan_token_type tok_in,
   output hbbtm_pkg::scan_token_type      tok_out
);
   localparam int BW = hbbtm_pkg::BKT_W;
   localparam logic [hbbtm_pkg::IDX_W-1:0] MY_IDX = hbbtm_pkg::IDX_W'(CELL_ID);

   logic [7:0]    dev_ff;
   logic [31:0]   blk_ff;
   logic [7:0]    cnt_ff;
   logic [31:0]   stamp_ff;
   logic          valid_ff;
   logic [BW-1:0] bucket_ff;
   logic [31:0]   place_ff;

   hbbtm_pkg::scan_token_type tok_ff, tok_in_next;
   logic [BW:0]   bkt_gap_wide;
   logic [BW-1:0] bkt_gap;
   logic          match, better;

   always_comb begin
      if (bucket_ff >= query.bkt) begin
         bkt_gap_wide = {1'b0, bucket_ff} - {1'b0, query.bkt};
      end else begin
         bkt_gap_wide = {1'b0, bucket_ff} + (BW+1)'(NUM_BUCKETS) - {1'b0, query.bkt};
      end
      bkt_gap = BW'(bkt_gap_wide);
      match = (bucket_ff == query.bkt) && (dev_ff == query.dev) && (blk_ff == query.blk);
      better = !tok_in.free_found || (bkt_gap < tok_in.free_dist) ||
               ((bkt_gap == tok_in.free_dist) && ((stamp_ff < tok_in.free_stamp) ||
               ((stamp_ff == tok_in.free_stamp) && (place_ff > tok_in.free_place))));

      tok_in_next = tok_in;
      if (match && (!tok_in.hit_found || (place_ff > tok_in.hit_place))) begin
         tok_in_next.hit_found = 1'b1;
         tok_in_next.hit_idx   = MY_IDX;
         tok_in_next.hit_place = place_ff;
         tok_in_next.hit_valid = valid_ff;
         tok_in_next.hit_cnt   = cnt_ff;
      end
      if ((cnt_ff == 8'd0) && better) begin
         tok_in_next.free_found = 1'b1;
         tok_in_next.free_idx   = MY_IDX;
         tok_in_next.free_dist  = bkt_gap;
         tok_in_next.free_stamp = stamp_ff;
         tok_in_next.free_place = place_ff;
      end
      if (query.idx == MY_IDX) begin
         tok_in_next.tgt_valid = valid_ff;
         tok_in_next.tgt_cnt   = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff    <= '0;
         blk_ff    <= '0;
         cnt_ff    <= '0;
         stamp_ff  <= '0;
         valid_ff  <= 1'b0;
         bucket_ff <= '0;
         place_ff  <= 32'(CELL_ID);
      end else if (upd.en && (upd.idx == MY_IDX)) begin
         if (upd.set_tag) begin
            dev_ff <= upd.dev;
            blk_ff <= upd.blk;
         end
         if (upd.set_cnt) begin
            cnt_ff <= upd.cnt;
         end
         if (upd.set_stamp) begin
            stamp_ff <= upd.stamp;
         end
         if (upd.set_valid) begin
            valid_ff <= 1'b1;
         end
         if (upd.set_bucket) begin
            bucket_ff <= upd.bkt;
            place_ff  <= upd.place;
         end
      end
   end

   assign tok_out = tok_ff;
endmodule
`default_nettype wire

>>> src/hashed_block_buffer_tag_manager_core.sv
// Tag manager for a hashed block-buffer cache with per-bucket LRU replacement.
// Request channel (req_*): action, device/block for get, entry index for
// release/pin/unpin, and the current tick. Response channel (rsp_*): slot,
// status and the prior data-valid bit, one response per request.
// A request is taken only when the block is idle (req_stall low). It folds
// (device*2591 + block) mod NUM_BUCKETS one byte per cycle in 4 steps, then a
// scan token walks the row of NUM_ENTRIES entry cells, one cell per cycle,
// collecting the tag hit, the best free victim and the addressed entry.
// The update state then writes the chosen entry and loads the response register.
// No new request is taken until that update has loaded the response register.
// Reset (synchronous) clears all tags, counts and stamps, puts every entry in
// bucket zero with placement order equal to its index, and empties the
// response register. A stalled response holds; the block then waits in its
// update state and writes nothing until the response register frees up.
`default_nettype none
module hashed_block_buffer_tag_manager_core #(
   parameter int NUM_ENTRIES = hbbtm_pkg::NUM_ENTRIES_DEF,
   parameter int NUM_BUCKETS = hbbtm_pkg::NUM_BUCKETS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_device_id,
   input  wire logic [31:0] req_block_number,
   input  wire logic [4:0]  req_entry_index,
   input  wire logic [31:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_slot,
   output logic [1:0]       rsp_status,
   output logic             rsp_was_valid
);
   localparam int SCW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int IW  = hbbtm_pkg::IDX_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_HASH = 4'b0010,
      S_SCAN = 4'b0100,
      S_UPD  = 4'b1000
   } state_type;

   state_type state_ff;
   hbbtm_pkg::action_type act_ff;
   hbbtm_pkg::query_type  query_ff;
   logic [31:0]   now_ff;
   logic [4:0]    eidx_ff;
   logic          in_range_ff;
   logic [SCW-1:0] scnt_ff;
   logic [31:0]   place_cnt_ff;

   logic          rsp_valid_ff;
   logic [4:0]    rsp_slot_ff, rsp_slot_in;
   hbbtm_pkg::status_type rsp_status_ff, rsp_status_in;
   logic          rsp_was_ff, rsp_was_in;

   logic          accept, go, hash_done;
   logic [hbbtm_pkg::BKT_W-1:0] hash_bucket;
   hbbtm_pkg::update_type     upd;
   hbbtm_pkg::scan_token_type chain [NUM_ENTRIES+1];
   hbbtm_pkg::scan_token_type fin;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign go        = (state_ff == S_UPD) && (!rsp_valid_ff || !rsp_stall);
   assign fin       = chain[NUM_ENTRIES];
   assign chain[0]  = '0;

   hbbtm_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .dev    (req_device_id),
      .blk    (req_block_number),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      hbbtm_cell #(.NUM_BUCKETS(NUM_BUCKETS), .CELL_ID(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .query   (query_ff),
         .upd     (upd),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   always_comb begin
      upd           = '0;
      upd.dev       = query_ff.dev;
      upd.blk       = query_ff.blk;
      upd.stamp     = now_ff;
      upd.bkt       = query_ff.bkt;
      upd.place     = place_cnt_ff;
      rsp_slot_in   = 5'd0;
      rsp_status_in = hbbtm_pkg::ST_HIT;
      rsp_was_in    = 1'b0;
      if (act_ff == hbbtm_pkg::ACT_GET) begin
         if (fin.hit_found) begin
            upd.idx       = fin.hit_idx;
            rsp_slot_in   = 5'(fin.hit_idx);
            rsp_was_in    = fin.hit_valid;
            upd.set_stamp = 1'b1;
            upd.set_valid = 1'b1;
            if (fin.hit_cnt == hbbtm_pkg::CNT_MAX) begin
               rsp_status_in = hbbtm_pkg::ST_SAT;
            end else begin
               upd.set_cnt = 1'b1;
               upd.cnt     = fin.hit_cnt + 8'd1;
            end
         end else if (fin.free_found) begin
            upd.idx        = fin.free_idx;
            rsp_slot_in    = 5'(fin.free_idx);
            rsp_status_in  = hbbtm_pkg::ST_MISS;
            upd.set_tag    = 1'b1;
            upd.set_cnt    = 1'b1;
            upd.cnt        = 8'd1;
            upd.set_stamp  = 1'b1;
            upd.set_valid  = 1'b1;
            upd.set_bucket = (fin.free_dist != '0);
         end else begin
            rsp_status_in = hbbtm_pkg::ST_NOBUF;
         end
      end else begin
         rsp_slot_in = eidx_ff;
         upd.idx     = query_ff.idx;
         if (!in_range_ff) begin
            rsp_status_in = hbbtm_pkg::ST_NOBUF;
         end else begin
            rsp_was_in = fin.tgt_valid;
            if (act_ff == hbbtm_pkg::ACT_PIN) begin
               if (fin.tgt_cnt == hbbtm_pkg::CNT_MAX) begin
                  rsp_status_in = hbbtm_pkg::ST_SAT;
               end else begin
                  upd.set_cnt = 1'b1;
                  upd.cnt     = fin.tgt_cnt + 8'd1;
               end
            end else begin
               if (fin.tgt_cnt == 8'd0) begin
                  rsp_status_in = hbbtm_pkg::ST_SAT;
               end else begin
                  upd.set_cnt = 1'b1;
                  upd.cnt     = fin.tgt_cnt - 8'd1;
               end
               upd.set_stamp = (act_ff == hbbtm_pkg::ACT_RELEASE);
            end
         end
      end
      upd.en = go && !(rsp_status_in == hbbtm_pkg::ST_NOBUF);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff       <= hbbtm_pkg::action_type'(req_action);
         query_ff.dev <= req_device_id;
         query_ff.blk <= req_block_number;
         query_ff.idx <= IW'(req_entry_index);
         now_ff       <= req_now;
         eidx_ff      <= req_entry_index;
         in_range_ff  <= (32'(req_entry_index) < 32'(NUM_ENTRIES));
      end
      if (hash_done) begin
         query_ff.bkt <= hash_bucket;
      end
      if (go) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= rsp_status_in;
         rsp_was_ff    <= rsp_was_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         place_cnt_ff <= 32'(NUM_ENTRIES);
      end else begin
         if (upd.en && upd.set_bucket) begin
            place_cnt_ff <= place_cnt_ff + 32'd1;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               if (hash_done) begin
                  state_ff <= S_SCAN;
                  scnt_ff  <= '0;
               end
            end
            S_SCAN: begin
               scnt_ff <= scnt_ff + SCW'(1);
               if (scnt_ff == SCW'(NUM_ENTRIES - 1)) begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (go) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_was_valid = rsp_was_ff;

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      (upd.en && upd.set_bucket) |=> (place_cnt_ff == $past(place_cnt_ff) + 32'd1))
      else $error("placement counter did not advance on bucket move");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPD))
      else $error("response appeared outside update cycle");

   a_hash_in_hash_state: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("hash finished outside hash state");

   a_retag_count: assert property (@(posedge clock) disable iff (reset)
      (upd.en && upd.set_tag) |-> (upd.set_cnt && (upd.cnt == 8'd1)))
      else $error("retagged entry not given count one");
endmodule
`default_nettype wire

>>> bench/tag_manager_checker.sv
`timescale 1ns / 1ps
module tag_manager_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_device_id,
   input  wire logic [31:0] req_block_number,
   input  wire logic [4:0]  req_entry_index,
   input  wire logic [31:0] req_now,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [4:0]  rsp_slot,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        rsp_was_valid,
   output int               fail_count,
   output int               pending_count
);
   localparam int NE = 32;
   localparam int NB = 13;

   typedef struct packed {
      logic [4:0]            slot;
      hbbtm_pkg::status_type status;
      logic                  was_valid;
   } answer_type;

   logic [7:0]  m_dev [NE];
   logic [31:0] m_blk [NE];
   logic [7:0]  m_cnt [NE];
   logic [31:0] m_stamp [NE];
   logic        m_valid [NE];
   logic [3:0]  m_bucket [NE];
   logic [31:0] m_place [NE];
   logic [31:0] place_next;
   answer_type  answers_due[$];

   function automatic int oldest_free_in(int b);
      int best;
      best = -1;
      for (int i = 0; i < NE; i++) begin
         if (m_bucket[i] != b || m_cnt[i] != 0) continue;
         if (best < 0 || m_stamp[i] < m_stamp[best] ||
             (m_stamp[i] == m_stamp[best] && m_place[i] > m_place[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic answer_type apply_request(hbbtm_pkg::action_type act, logic [7:0] dev,
         logic [31:0] blk, logic [4:0] idx, logic [31:0] now);
      answer_type a;
      logic [31:0] h;
      int hit, e, b;
      a = '{slot: 5'd0, status: hbbtm_pkg::ST_HIT, was_valid: 1'b0};
      if (act == hbbtm_pkg::ACT_GET) begin
         h = ({24'd0, dev} * 32'd2591 + blk) % NB;
         hit = -1;
         for (int i = 0; i < NE; i++)
            if (m_bucket[i] == h && m_dev[i] == dev && m_blk[i] == blk &&
                (hit < 0 || m_place[i] > m_place[hit]))
               hit = i;
         if (hit >= 0) begin
            a.slot = 5'(hit);
            a.was_valid = m_valid[hit];
            if (m_cnt[hit] == 8'd255) a.status = hbbtm_pkg::ST_SAT;
            else m_cnt[hit]++;
            m_stamp[hit] = now;
            m_valid[hit] = 1'b1;
         end else begin
            e = oldest_free_in(int'(h));
            if (e < 0) begin
               b = int'(h);
               for (int c = 1; c < NB && e < 0; c++) begin
                  b = (b + 1) % NB;
                  e = oldest_free_in(b);
               end
               if (e >= 0) begin
                  m_bucket[e] = 4'(h);
                  m_place[e] = place_next;
                  place_next++;
               end
            end
            if (e < 0) begin
               a.status = hbbtm_pkg::ST_NOBUF;
            end else begin
               m_dev[e] = dev;
               m_blk[e] = blk;
               m_cnt[e] = 8'd1;
               m_stamp[e] = now;
               m_valid[e] = 1'b1;
               a.slot = 5'(e);
               a.status = hbbtm_pkg::ST_MISS;
            end
         end
      end else begin
         a.slot = idx;
         a.was_valid = m_valid[idx];
         if (act == hbbtm_pkg::ACT_PIN) begin
            if (m_cnt[idx] == 8'd255) a.status = hbbtm_pkg::ST_SAT;
            else m_cnt[idx]++;
         end else begin
            if (m_cnt[idx] == 8'd0) a.status = hbbtm_pkg::ST_SAT;
            else m_cnt[idx]--;
            if (act == hbbtm_pkg::ACT_RELEASE) m_stamp[idx] = now;
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < NE; i++) begin
            m_dev[i] = 8'd0;
            m_blk[i] = 32'd0;
            m_cnt[i] = 8'd0;
            m_stamp[i] = 32'd0;
            m_valid[i] = 1'b0;
            m_bucket[i] = 4'd0;
            m_place[i] = 32'(i);
         end
         place_next = 32'(NE);
         answers_due.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected transfer: slot %0d status %0d", rsp_slot, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (rsp_slot !== want.slot || rsp_status !== want.status ||
                   rsp_was_valid !== want.was_valid) begin
                  fail_count <= fail_count + 1;
                  if (rsp_slot !== want.slot)
                     $error("slot: expected %0d actual %0d", want.slot, rsp_slot);
                  if (rsp_status !== want.status)
                     $error("status: expected %0d actual %0d", want.status, rsp_status);
                  if (rsp_was_valid !== want.was_valid)
                     $error("was_valid: expected %0d actual %0d", want.was_valid,
                            rsp_was_valid);
               end
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(apply_request(hbbtm_pkg::action_type'(req_action),
                                                req_device_id, req_block_number,
                                                req_entry_index, req_now));
         pending_count <= answers_due.size();
      end
   end
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = hbbtm_pkg::ACT_GET;
   logic [7:0]  req_device_id = '0;
   logic [31:0] req_block_number = '0;
   logic [4:0]  req_entry_index = '0;
   logic [31:0] req_now = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_slot;
   logic [1:0]  rsp_status;
   logic        rsp_was_valid;
   int          fail_count;
   int          pending_count;
   logic        busy_mode = 1'b1;
   logic [31:0] tick = 32'd100;
   int          idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hashed_block_buffer_tag_manager_core i_dut (.*);

   tag_manager_checker i_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL hashed_block_buffer_tag_manager_core");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= busy_mode && ($urandom_range(99) < 20);

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send(hbbtm_pkg::action_type act, logic [7:0] dev, logic [31:0] blk,
                       logic [4:0] idx, logic [31:0] now);
      while (busy_mode && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_device_id <= dev;
      req_block_number <= blk;
      req_entry_index <= idx;
      req_now <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      int r;
      logic [31:0] blk;
      r = $urandom_range(99);
      tick = tick + $urandom_range(3);
      blk = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
      if (r < 45)
         send(hbbtm_pkg::ACT_GET,
              ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2)), blk,
              5'($urandom), ($urandom_range(9) == 0) ? $urandom : tick);
      else if (r < 75)
         send(hbbtm_pkg::ACT_RELEASE, 8'($urandom), $urandom, 5'($urandom_range(31)), tick);
      else if (r < 88)
         send(hbbtm_pkg::ACT_PIN, 8'($urandom), $urandom, 5'($urandom_range(31)), $urandom);
      else
         send(hbbtm_pkg::ACT_UNPIN, 8'($urandom), $urandom, 5'($urandom_range(31)),
              $urandom);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // reset tag hit, miss then hit, and pin/unpin counts at both limits
      send(hbbtm_pkg::ACT_GET, 8'd0, 32'd0, 5'd0, 32'd5);
      send(hbbtm_pkg::ACT_GET, 8'd255, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
      send(hbbtm_pkg::ACT_GET, 8'd1, 32'd7, 5'd0, 32'd0);
      send(hbbtm_pkg::ACT_GET, 8'd1, 32'd7, 5'd0, 32'd6);
      send(hbbtm_pkg::ACT_RELEASE, 8'd0, 32'd0, 5'd31, 32'd9);
      send(hbbtm_pkg::ACT_RELEASE, 8'd0, 32'd0, 5'd3, 32'd9);
      send(hbbtm_pkg::ACT_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd4, 32'hFFFF_FFFF);
      send(hbbtm_pkg::ACT_PIN, 8'd0, 32'd0, 5'd4, 32'd0);
      for (int i = 0; i < 256; i++)
         send(hbbtm_pkg::ACT_PIN, 8'd0, 32'd0, 5'd10, 32'd1);
      send(hbbtm_pkg::ACT_UNPIN, 8'd0, 32'd0, 5'd10, 32'd1);
      // take every free entry, then run out of buffers
      for (int i = 0; i < 34; i++)
         send(hbbtm_pkg::ACT_GET, 8'd2, 32'(i * 13), 5'd0, 32'd20 + 32'(i));
      for (int i = 0; i < 32; i++)
         send(hbbtm_pkg::ACT_RELEASE, 8'd0, 32'd0, 5'(i), 32'd50);
      busy_mode <= 1'b0;
      for (int i = 0; i < 100; i++) send_random();
      busy_mode <= 1'b1;
      for (int i = 0; i < 170; i++) send_random();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("PASS hashed_block_buffer_tag_manager_core");
      else
         $display("FAIL hashed_block_buffer_tag_manager_core");
      $finish;
   end
endmodule
